// ===== rtl/mzr_pkg.sv =====
// shared types and constants of the zero-run encoder
`timescale 1ns / 1ps

package mzr_pkg;

    localparam int RUN_DIGITS  = 24;
    localparam int RUN_W       = RUN_DIGITS + 1;
    localparam int IDX_W       = 8;
    localparam int SYM_W       = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [RUN_W-1:0] RUN_MAX      = {{(RUN_W-1){1'b1}}, 1'b0};
    localparam logic [SYM_W-1:0] SYM_END_BLK  = SYM_W'(257);

    // one flush command: run value n+1 (1 means no run), optional index, optional end
    typedef struct packed {
        logic [RUN_W-1:0] run_val;
        logic             idx_pend;
        logic [IDX_W-1:0] idx;
        logic             end_pend;
    } t_cmd;

endpackage

// ===== rtl/mzr_front.sv =====
// front end: run counting and classification of incoming indices
`timescale 1ns / 1ps

module mzr_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [mzr_pkg::IDX_W-1:0] i_mtf_index,
    input  logic                     i_block_end,
    input  logic                     i_q_full,
    output logic                     o_full,
    output logic                     o_cmd_push,
    output mzr_pkg::t_cmd            o_cmd
);
    import mzr_pkg::*;

    logic [RUN_W-1:0] r_run_cnt;
    logic [RUN_W-1:0] n_run_cnt;
    logic [RUN_W-1:0] run_sat;
    logic             accept;
    logic             idx_zero;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign idx_zero = (i_mtf_index == '0);
    assign run_sat  = (r_run_cnt < RUN_MAX) ? r_run_cnt + RUN_W'(1) : r_run_cnt;

    always_comb begin
        n_run_cnt        = r_run_cnt;
        o_cmd_push       = 1'b0;
        o_cmd.run_val    = r_run_cnt + RUN_W'(1);
        o_cmd.idx_pend   = !idx_zero;
        o_cmd.idx        = i_mtf_index;
        o_cmd.end_pend   = i_block_end;
        if (accept) begin
            if (idx_zero) begin
                // zero joins the run, flushed only at block end
                o_cmd.run_val = run_sat + RUN_W'(1);
                if (i_block_end) begin
                    o_cmd_push = 1'b1;
                    n_run_cnt  = '0;
                end else begin
                    n_run_cnt  = run_sat;
                end
            end else begin
                o_cmd_push = 1'b1;
                n_run_cnt  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_cnt <= '0;
        end else begin
            r_run_cnt <= n_run_cnt;
        end
    end

endmodule

// ===== rtl/mzr_queue.sv =====
// short command queue between front and back end
`timescale 1ns / 1ps

module mzr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  mzr_pkg::t_cmd i_wr_cmd,
    output logic          o_full,
    input  logic          i_rd,
    output logic          o_valid,
    output mzr_pkg::t_cmd o_rd_cmd
);
    import mzr_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_wr;
    logic              do_rd;

    assign o_full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_rd_cmd = r_slot[r_rd_ptr];
    assign do_wr    = i_wr && !o_full;
    assign do_rd    = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_slot[r_wr_ptr] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/mzr_back.sv =====
// back end: serial run digits, index and end symbols, output register
`timescale 1ns / 1ps

module mzr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  mzr_pkg::t_cmd             i_cmd,
    output logic                      o_cmd_ready,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic [mzr_pkg::SYM_W-1:0] o_symbol,
    output logic                      o_last_of_run
);
    import mzr_pkg::*;

    logic             r_busy;
    logic [RUN_W-1:0] r_val;
    logic             r_idx_pend;
    logic [IDX_W-1:0] r_idx;
    logic             r_end_pend;
    logic             r_out_valid;
    logic [SYM_W-1:0] r_sym;
    logic             r_last;

    logic             n_busy;
    logic [RUN_W-1:0] n_val;
    logic             n_idx_pend;
    logic             n_end_pend;
    logic             n_out_valid;
    logic [SYM_W-1:0] n_sym;
    logic             n_last;
    logic             slot_free;
    logic             digit_left;
    logic             load;

    assign o_cmd_ready   = !r_busy;
    assign load          = !r_busy && i_cmd_valid;
    assign o_empty       = !r_out_valid;
    assign o_symbol      = r_sym;
    assign o_last_of_run = r_last;
    assign slot_free     = !r_out_valid || i_pop;
    // digits remain while the shifted value is above one
    assign digit_left    = (r_val[RUN_W-1:1] != '0);

    always_comb begin
        n_busy      = r_busy;
        n_val       = r_val;
        n_idx_pend  = r_idx_pend;
        n_end_pend  = r_end_pend;
        n_sym       = r_sym;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_pop;
        if (r_busy && slot_free) begin
            n_out_valid = 1'b1;
            if (digit_left) begin
                n_sym  = SYM_W'(r_val[0]);
                n_val  = r_val >> 1;
                n_last = (r_val[RUN_W-1:2] == '0) && !r_idx_pend && !r_end_pend;
            end else if (r_idx_pend) begin
                n_sym      = SYM_W'(r_idx) + SYM_W'(1);
                n_last     = !r_end_pend;
                n_idx_pend = 1'b0;
            end else begin
                n_sym      = SYM_END_BLK;
                n_last     = 1'b1;
                n_end_pend = 1'b0;
            end
            n_busy = !n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_val <= i_cmd.run_val;
            r_idx <= i_cmd.idx;
        end else begin
            r_val <= n_val;
        end
        r_sym  <= n_sym;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx_pend  <= 1'b0;
            r_end_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (load) begin
                r_busy     <= 1'b1;
                r_idx_pend <= i_cmd.idx_pend;
                r_end_pend <= i_cmd.end_pend;
            end else begin
                r_busy     <= n_busy;
                r_idx_pend <= n_idx_pend;
                r_end_pend <= n_end_pend;
            end
        end
    end

endmodule

// ===== rtl/mtf_zero_run_encoder.sv =====
// top level of the move-to-front zero-run encoder
`timescale 1ns / 1ps

// Zero-run encoder for move-to-front indices. Each request on the input queue
// carries one index and a block-end mark. A zero index only extends the pending
// run (saturating at 2^25-2) and produces nothing; a nonzero index or the end
// of a block flushes the run as floor(log2(n+1)) digit symbols 0/1, least
// significant first, then sends index+1 and, at block end, symbol 257. The
// last symbol caused by a request has last_of_run set. A flushing request is
// queued as one command (two-entry queue); the back end loads it into its shift
// register when idle, then emits one symbol per cycle from it as long as the
// output register is free or being popped, and the front keeps taking requests
// until the queue fills. Symbols wait in a single output register that pop
// drains. No startup sweep: the block takes requests from the first cycle after
// reset.

module mtf_zero_run_encoder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [mzr_pkg::IDX_W-1:0] i_mtf_index,
    input  logic                      i_block_end,
    output logic                      empty,
    input  logic                      pop,
    output logic [mzr_pkg::SYM_W-1:0] o_symbol,
    output logic                      o_last_of_run
);
    import mzr_pkg::*;

    logic q_full;
    logic cmd_push;
    t_cmd cmd_in;
    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd_out;

    // run counting and command build
    mzr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_mtf_index (i_mtf_index),
        .i_block_end (i_block_end),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    // decouples the front from the symbol emitter
    mzr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (cmd_push),
        .i_wr_cmd (cmd_in),
        .o_full   (q_full),
        .i_rd     (cmd_ready),
        .o_valid  (cmd_valid),
        .o_rd_cmd (cmd_out)
    );

    // one symbol per cycle into the output register while it is free or popped
    mzr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd_out),
        .o_cmd_ready   (cmd_ready),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_symbol      (o_symbol),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== rtl/mzr_checker.sv =====
// port-level checks of the zero-run encoder and their binding
`timescale 1ns / 1ps

module mzr_sva_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic [mzr_pkg::SYM_W-1:0] o_symbol,
    input logic                      o_last_of_run
);
    import mzr_pkg::*;

    // waiting symbol holds until popped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_symbol) && $stable(o_last_of_run)))
        else $error("waiting symbol changed");

    // no symbol code beyond end of block
    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_symbol <= SYM_END_BLK))
        else $error("symbol out of range");

    // end of block always closes its request
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_symbol == SYM_END_BLK) |-> o_last_of_run)
        else $error("end of block not marked last");

    // reset leaves nothing waiting and room for requests
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("reset did not clear queues");

endmodule

bind mtf_zero_run_encoder mzr_sva_checker u_mzr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .o_symbol      (o_symbol),
    .o_last_of_run (o_last_of_run)
);
